// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation and status codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_UNDER = 2'd1;
  localparam logic [1:0] STATUS_OVER  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

// ----- design/spq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences capture, execution and result handoff for one item at a time.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output spq_pkg::cmd_t      cmd
);

  spq_pkg::state_t state_r;
  spq_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        state_nxt = spq_pkg::ST_RESP;
      end
      spq_pkg::ST_RESP: begin
        if (out_ready) begin
          state_nxt = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == spq_pkg::ST_IDLE);
  assign out_valid = (state_r == spq_pkg::ST_RESP);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.exec  = (state_r == spq_pkg::ST_EXEC);

endmodule

`default_nettype wire

// ----- design/spq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// A row of cells kept sorted by priority, with parallel insert and head shift.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spq_pkg::cmd_t      cmd,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [31:0] in_data_in,
  input  wire logic signed [15:0] in_priority_in,
  output logic signed [31:0]      out_data_out,
  output logic [1:0]              out_status,
  output logic [3:0]              out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]         op_mode_r;
  logic signed [31:0] op_data_r;
  logic signed [15:0] op_prio_r;

  logic signed [31:0] data_r   [DEPTH];
  logic signed [15:0] prio_r   [DEPTH];
  logic signed [31:0] data_nxt [DEPTH];
  logic signed [15:0] prio_nxt [DEPTH];
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [DEPTH-1:0]   le;

  logic signed [31:0] res_data_r;
  logic [1:0]         res_status_r;
  logic [CW-1:0]      res_count_r;
  logic signed [31:0] res_data_nxt;
  logic [1:0]         res_status_nxt;

  logic full;
  logic empty;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CW'(i) < count_r) && (prio_r[i] <= op_prio_r);
    end
  end

  always_comb begin
    count_nxt      = count_r;
    res_data_nxt   = '0;
    res_status_nxt = spq_pkg::STATUS_OK;
    for (int i = 0; i < DEPTH; i++) begin
      data_nxt[i] = data_r[i];
      prio_nxt[i] = prio_r[i];
    end
    case (op_mode_r)
      spq_pkg::MODE_ENQ: begin
        if (full) begin
          res_status_nxt = spq_pkg::STATUS_OVER;
        end else begin
          count_nxt = count_r + CW'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (!le[i]) begin
              if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
                data_nxt[i] = op_data_r;
                prio_nxt[i] = op_prio_r;
              end else begin
                data_nxt[i] = data_r[(i == 0) ? 0 : i - 1];
                prio_nxt[i] = prio_r[(i == 0) ? 0 : i - 1];
              end
            end
          end
        end
      end
      spq_pkg::MODE_DEQ, spq_pkg::MODE_PEEK: begin
        if (empty) begin
          res_status_nxt = spq_pkg::STATUS_UNDER;
        end else begin
          res_data_nxt = data_r[0];
          if (op_mode_r == spq_pkg::MODE_DEQ) begin
            count_nxt = count_r - CW'(1);
            for (int i = 0; i < DEPTH - 1; i++) begin
              data_nxt[i] = data_r[i + 1];
              prio_nxt[i] = prio_r[i + 1];
            end
          end
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode_r <= in_mode;
      op_data_r <= in_data_in;
      op_prio_r <= in_priority_in;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        data_r[i] <= data_nxt[i];
        prio_r[i] <= prio_nxt[i];
      end
      res_data_r   <= res_data_nxt;
      res_status_r <= res_status_nxt;
      res_count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_data_out  = res_data_r;
  assign out_status    = res_status_r;
  assign out_occupancy = 4'(res_count_r);

endmodule

`default_nettype wire

// ----- design/sorted_priority_queue_core.sv -----
// Timing: an accepted item passes through the execute state, where its result is
// registered, before out_valid rises in the handoff state.
// Items are handled one at a time: the next is accepted only after the controller's
// capture, execute and handoff states; a stalled result holds the next item.
// Reset: synchronous, active low; the queue is emptied at once and the
// entry cells are left as they are.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded queue kept sorted by priority, with enqueue, dequeue and peek items.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [31:0] in_data_in,
  input  wire logic signed [15:0] in_priority_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_data_out,
  output logic [1:0]              out_status,
  output logic [3:0]              out_occupancy
);

  spq_pkg::cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_data_in     (in_data_in),
    .in_priority_in (in_priority_in),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy)
  );

endmodule

`default_nettype wire
